>>> sv/pft_pkg.sv
// Package for the polygon fan triangulator: sizes, action codes and the
// control structs passed between the top level and the hole table unit.
// No dependencies.
package pft_pkg;

	localparam int MAX_HOLES  = 16;
	localparam int HOLE_IDX_W = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
	localparam int HOLE_CNT_W = $clog2(MAX_HOLES + 1);
	localparam int DATA_W     = 32;

	typedef enum logic [1:0] {
		ACT_BEGIN  = 2'd0,
		ACT_HOLE   = 2'd1,
		ACT_HEADER = 2'd2,
		ACT_VERTEX = 2'd3
	} action_t;

	// Fan position saturates at the third vertex
	localparam logic [1:0] POS_FIRST = 2'd0;
	localparam logic [1:0] POS_THIRD = 2'd2;

	typedef struct packed {
		logic              clear;
		logic              add;
		logic [DATA_W-1:0] hole;
		logic              scan;
		logic [DATA_W-1:0] face;
	} hole_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic hit;
	} hole_sts_t;

endpackage

>>> sv/pft_in_if.sv
// Input channel of the triangulator: valid/ready handshake with one item.
// Depends on pft_pkg for the field widths.
interface pft_in_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                action;
	logic [pft_pkg::DATA_W-1:0] hole_face;
	logic [pft_pkg::DATA_W-1:0] vertex_count;
	logic [pft_pkg::DATA_W-1:0] vertex_index;

	modport source (output valid, action, hole_face, vertex_count, vertex_index, input ready);
	modport sink (input valid, action, hole_face, vertex_count, vertex_index, output ready);
endinterface

>>> sv/pft_out_if.sv
// Output channel of the triangulator: valid/ready handshake, one triangle.
// Depends on pft_pkg for the field widths.
interface pft_out_if;
	logic                      valid;
	logic                      ready;
	logic [pft_pkg::DATA_W-1:0] corner_a;
	logic [pft_pkg::DATA_W-1:0] corner_b;
	logic [pft_pkg::DATA_W-1:0] corner_c;
	logic [pft_pkg::DATA_W-1:0] source_face;

	modport source (output valid, corner_a, corner_b, corner_c, source_face, input ready);
	modport sink (input valid, corner_a, corner_b, corner_c, source_face, output ready);
endinterface

>>> sv/pft_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pft_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> sv/pft_hole_unit.sv
// Hole table: stores hole face numbers in a RAM and scans it one entry a
// cycle through a single comparator. Depends on pft_pkg and pft_ram.
module pft_hole_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  pft_pkg::hole_cmd_t cmd,
	output pft_pkg::hole_sts_t sts
);
	import pft_pkg::*;

	typedef enum logic [1:0] {
		SC_IDLE = 2'b01,
		SC_RUN  = 2'b10
	} scan_state_t;

	scan_state_t             state_q;
	logic [HOLE_CNT_W-1:0]   cnt_q;
	logic [HOLE_CNT_W-1:0]   addr_q;
	logic [DATA_W-1:0]       face_q;
	logic                    rd_vld_s1;
	logic [DATA_W-1:0]       rdata;
	logic                    wr_en;
	logic                    rd_en;
	logic                    hit;
	logic                    finish;

	assign wr_en  = cmd.add && (cnt_q < HOLE_CNT_W'(MAX_HOLES));
	assign rd_en  = (state_q == SC_RUN) && (addr_q < cnt_q);
	assign hit    = rd_vld_s1 && (rdata == face_q);
	// Stop on a match, or once no entry is left to read; the last read is
	// compared in that same cycle
	assign finish = (state_q == SC_RUN) && (hit || !rd_en);

	pft_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_HOLES)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cnt_q[HOLE_IDX_W-1:0]),
		.wdata (cmd.hole),
		.re    (rd_en),
		.raddr (addr_q[HOLE_IDX_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SC_IDLE;
			cnt_q     <= '0;
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.clear) begin
				cnt_q <= '0;
			end else if (wr_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			case (state_q)
				SC_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (cmd.scan) begin
						state_q <= SC_RUN;
						addr_q  <= '0;
					end
				end
				SC_RUN: begin
					if (finish) begin
						state_q   <= SC_IDLE;
						rd_vld_s1 <= 1'b0;
					end else begin
						rd_vld_s1 <= rd_en;
						if (rd_en) begin
							addr_q <= addr_q + 1'b1;
						end
					end
				end
				default: begin
					state_q   <= SC_IDLE;
					rd_vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && state_q == SC_IDLE) begin
			face_q <= cmd.face;
		end
	end

	assign sts.busy = (state_q == SC_RUN);
	assign sts.done = finish;
	assign sts.hit  = hit;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= HOLE_CNT_W'(MAX_HOLES))
		else $error("hole count beyond table size");
	a_addr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (addr_q <= cnt_q))
		else $error("scan address ran past hole count");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |=> !sts.busy && !rd_vld_s1)
		else $error("scan did not stop after done");
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> !cmd.add && !cmd.clear)
		else $error("table changed during scan");
`endif
endmodule

>>> sv/polygon_fan_triangulator_top.sv
// Polygon fan triangulator top level: face and vertex sequencing, the
// triangle output register and the orientation register.
// Depends on pft_pkg, pft_in_if, pft_out_if and pft_hole_unit.
//
//   channel   handshake          payload
//   in_ch     valid / ready      action, hole_face, vertex_count, vertex_index
//   out_ch    valid / ready      corner_a, corner_b, corner_c, source_face
//   cfg       cfg_we (no wait)   cfg_wdata: right_handed
//
// A face header starts a scan of the hole table: the RAM is read one entry a
// cycle through one comparator, stopping at the first match.
// No clearing pass after reset; unwritten table entries are never read.
// A finished triangle waits in the output register; input stalls only while
// that register is full and not being taken, or during a header scan.
module polygon_fan_triangulator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	pft_in_if.sink      in_ch,
	pft_out_if.source   out_ch
);
	import pft_pkg::*;

	hole_cmd_t          cmd;
	hole_sts_t          sts;
	logic               right_handed_q;
	logic [DATA_W-1:0]  next_face_q;
	logic [DATA_W-1:0]  cur_face_q;
	logic               face_hole_q;
	logic [DATA_W-1:0]  vleft_q;
	logic [1:0]         pos_q;
	logic [DATA_W-1:0]  apex_q;
	logic [DATA_W-1:0]  prev_q;
	logic               out_vld_q;
	logic [DATA_W-1:0]  corner_a_q;
	logic [DATA_W-1:0]  corner_b_q;
	logic [DATA_W-1:0]  corner_c_q;
	logic [DATA_W-1:0]  face_out_q;
	logic               acc;
	logic               take_vtx;
	logic               emit;
	action_t            act;

	assign act      = action_t'(in_ch.action);
	assign in_ch.ready = !sts.busy && (!out_vld_q || out_ch.ready);
	assign acc      = in_ch.valid && in_ch.ready;
	assign take_vtx = acc && (act == ACT_VERTEX) && (vleft_q != '0);
	assign emit     = take_vtx && (pos_q == POS_THIRD) && !face_hole_q;

	assign cmd.clear = acc && (act == ACT_BEGIN);
	assign cmd.add   = acc && (act == ACT_HOLE);
	assign cmd.hole  = in_ch.hole_face;
	assign cmd.scan  = acc && (act == ACT_HEADER);
	assign cmd.face  = next_face_q;

	pft_hole_unit u_holes (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_handed_q <= 1'b1;
			next_face_q    <= '0;
			cur_face_q     <= '0;
			face_hole_q    <= 1'b0;
			vleft_q        <= '0;
			pos_q          <= POS_FIRST;
			apex_q         <= '0;
			prev_q         <= '0;
			out_vld_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				right_handed_q <= cfg_wdata;
			end
			if (sts.done) begin
				face_hole_q <= sts.hit;
			end
			if (acc) begin
				case (act)
					ACT_BEGIN: begin
						next_face_q <= '0;
						vleft_q     <= '0;
						pos_q       <= POS_FIRST;
					end
					ACT_HEADER: begin
						cur_face_q  <= next_face_q;
						next_face_q <= next_face_q + 1'b1;
						vleft_q     <= in_ch.vertex_count;
						pos_q       <= POS_FIRST;
					end
					ACT_VERTEX: begin
						if (take_vtx) begin
							vleft_q <= vleft_q - 1'b1;
							prev_q  <= in_ch.vertex_index;
							if (pos_q == POS_FIRST) begin
								apex_q <= in_ch.vertex_index;
							end
							if (pos_q != POS_THIRD) begin
								pos_q <= pos_q + 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
			// Load wins over drain; ready guarantees the register is free
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			corner_a_q <= apex_q;
			corner_b_q <= right_handed_q ? prev_q : in_ch.vertex_index;
			corner_c_q <= right_handed_q ? in_ch.vertex_index : prev_q;
			face_out_q <= cur_face_q;
		end
	end

	assign out_ch.valid       = out_vld_q;
	assign out_ch.corner_a    = corner_a_q;
	assign out_ch.corner_b    = corner_b_q;
	assign out_ch.corner_c    = corner_c_q;
	assign out_ch.source_face = face_out_q;

`ifndef SYNTHESIS
	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> !acc)
		else $error("item accepted during hole scan");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 2'd3)
		else $error("fan position out of range");
	a_emit_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_vld_q || out_ch.ready))
		else $error("triangle overwrote pending output");
	a_header_scans: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |=> sts.busy)
		else $error("header did not start a hole scan");
`endif
endmodule

>>> sim/pft_checker.sv
// Checker for the polygon fan triangulator: tracks accepted items and
// orientation writes, predicts the fan triangles and compares each output.
// Depends on pft_pkg, pft_in_if and pft_out_if.
module pft_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	pft_in_if    in_mon,
	pft_out_if   out_mon,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import pft_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] c;
		logic [DATA_W-1:0] face;
	} triangle_t;

	logic [DATA_W-1:0] holes [MAX_HOLES];
	int unsigned       hole_cnt;
	logic [DATA_W-1:0] face_ctr;
	logic [DATA_W-1:0] open_face;
	logic [DATA_W-1:0] verts_left;
	logic [DATA_W-1:0] apex;
	logic [DATA_W-1:0] prev_vtx;
	logic [1:0]        fan_pos;
	logic              skip_face;
	logic              right_handed;
	triangle_t         tri_q[$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	task automatic report_mismatch(string what);
		fail_count++;
		// keep the log short on a badly broken block
		if (fail_count <= 100)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	function automatic logic listed_hole(logic [DATA_W-1:0] face);
		for (int k = 0; k < hole_cnt; k++)
			if (holes[k] == face)
				return 1'b1;
		return 1'b0;
	endfunction

	task automatic predict_item(action_t act, logic [DATA_W-1:0] hole,
			logic [DATA_W-1:0] cnt, logic [DATA_W-1:0] vtx);
		triangle_t t;
		case (act)
		ACT_BEGIN: begin
			hole_cnt = 0;
			face_ctr = '0;
			verts_left = '0;
			fan_pos = POS_FIRST;
		end
		ACT_HOLE: begin
			// drop holes once the table is full
			if (hole_cnt < MAX_HOLES) begin
				holes[hole_cnt] = hole;
				hole_cnt++;
			end
		end
		ACT_HEADER: begin
			open_face = face_ctr;
			face_ctr = face_ctr + 1'b1;
			skip_face = listed_hole(open_face);
			verts_left = cnt;
			fan_pos = POS_FIRST;
		end
		default: begin
			if (verts_left != '0) begin
				verts_left = verts_left - 1'b1;
				if (fan_pos == POS_FIRST)
					apex = vtx;
				if (fan_pos == POS_THIRD && !skip_face) begin
					t.a = apex;
					t.b = right_handed ? prev_vtx : vtx;
					t.c = right_handed ? vtx : prev_vtx;
					t.face = open_face;
					tri_q.push_back(t);
				end
				prev_vtx = vtx;
				if (fan_pos != POS_THIRD)
					fan_pos = fan_pos + 1'b1;
			end
		end
		endcase
	endtask

	task automatic check_triangle();
		triangle_t want;
		if (tri_q.size() == 0) begin
			report_mismatch($sformatf("unexpected triangle %h %h %h face %h",
				out_mon.corner_a, out_mon.corner_b, out_mon.corner_c,
				out_mon.source_face));
			return;
		end
		want = tri_q.pop_front();
		if (out_mon.corner_a !== want.a || out_mon.corner_b !== want.b ||
				out_mon.corner_c !== want.c || out_mon.source_face !== want.face)
			report_mismatch($sformatf("got %h %h %h face %h, want %h %h %h face %h",
				out_mon.corner_a, out_mon.corner_b, out_mon.corner_c,
				out_mon.source_face, want.a, want.b, want.c, want.face));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_cnt = 0;
			face_ctr = '0;
			open_face = '0;
			verts_left = '0;
			apex = '0;
			prev_vtx = '0;
			fan_pos = POS_FIRST;
			skip_face = 1'b0;
			right_handed = 1'b1;
			tri_q.delete();
		end else begin
			if (cfg_we)
				right_handed = cfg_wdata;
			// outputs come from earlier items, so check before predicting
			if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1)
				check_triangle();
			if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
				predict_item(action_t'(in_mon.action), in_mon.hole_face,
					in_mon.vertex_count, in_mon.vertex_index);
		end
	end

	always @(negedge clk)
		pending = tri_q.size();

endmodule

>>> sim/tb.sv
// Testbench top for the polygon fan triangulator: clock, reset, mesh item
// stimulus, output back-pressure and the verdict.
// Depends on pft_pkg, pft_in_if, pft_out_if, pft_checker and the block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pft_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = MAX_HOLES + 8;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 175;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int   fail_count;
	int   pending;
	int   cycles;
	int   sent_items;
	int   src_idle;
	int   sink_stall;
	bit   hold_req;

	int src_idle_by_phase [4]   = '{0, 58, 0, 33};
	int sink_stall_by_phase [4] = '{0, 0, 58, 33};

	pft_in_if  in_ch();
	pft_out_if out_ch();

	polygon_fan_triangulator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	pft_checker tri_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_mon    (in_ch),
		.out_mon   (out_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	// Output side: random stalls, plus one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ch.ready <= ($urandom_range(99) >= sink_stall);
		end
	end

	// Offer one item; fields the action does not use carry noise
	task automatic send_op(action_t act, logic [DATA_W-1:0] val, bit counted = 1'b1);
		logic [DATA_W-1:0] h;
		logic [DATA_W-1:0] n;
		logic [DATA_W-1:0] v;
		h = $urandom;
		n = $urandom;
		v = $urandom;
		case (act)
		ACT_HOLE:   h = val;
		ACT_HEADER: n = val;
		ACT_VERTEX: v = val;
		default: ;
		endcase
		while ($urandom_range(99) < src_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.hole_face <= h;
		in_ch.vertex_count <= n;
		in_ch.vertex_index <= v;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		if (counted)
			sent_items++;
	endtask

	// Hold the input idle until every predicted triangle has arrived
	task automatic drain(int extra);
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_orientation(logic rh);
		drain(SETTLE);
		cfg_we <= 1'b1;
		cfg_wdata <= rh;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_mesh(int max_faces);
		int n_holes;
		int n_faces;
		int n_verts;
		int r;
		logic [DATA_W-1:0] cnt;
		send_op(ACT_BEGIN, '0);
		n_holes = ($urandom_range(4) == 0) ? $urandom_range(20, 14) : $urandom_range(4);
		n_faces = $urandom_range(max_faces, 1);
		for (int k = 0; k < n_holes; k++)
			send_op(ACT_HOLE, ($urandom_range(9) < 7) ? $urandom_range(n_faces + 1) : $urandom,
				k < MAX_HOLES);
		for (int f = 0; f < n_faces; f++) begin
			r = $urandom_range(99);
			if (r < 85)
				cnt = $urandom_range(7);
			else if (r < 95)
				cnt = $urandom_range(24, 8);
			else
				cnt = $urandom;
			send_op(ACT_HEADER, cnt);
			if (cnt > 24)
				n_verts = $urandom_range(6);
			else if ($urandom_range(6) == 0)
				n_verts = $urandom_range(cnt + 2);
			else
				n_verts = cnt;
			for (int k = 0; k < n_verts; k++)
				send_op(ACT_VERTEX, $urandom, k < cnt);
			if ($urandom_range(19) == 0)
				send_op(action_t'($urandom_range(3)), $urandom, 1'b0);
		end
	endtask

	initial begin
		int target;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_BEGIN;
		in_ch.hole_face = '0;
		in_ch.vertex_count = '0;
		in_ch.vertex_index = '0;
		src_idle = 0;
		sink_stall = 0;
		hold_req = 1'b0;
		sent_items = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_orientation(1'b1);

		// vertex before any header is ignored
		send_op(ACT_VERTEX, 32'h0000_1234, 1'b0);
		send_op(ACT_HEADER, 32'd4);
		send_op(ACT_VERTEX, 32'h0000_0000);
		send_op(ACT_VERTEX, 32'hFFFF_FFFF);
		send_op(ACT_VERTEX, 32'h8000_0000);
		send_op(ACT_VERTEX, 32'h0000_0007);
		// faces too short for a triangle
		send_op(ACT_HEADER, 32'd2);
		send_op(ACT_VERTEX, $urandom);
		send_op(ACT_VERTEX, $urandom);
		send_op(ACT_HEADER, 32'd0);
		// huge face abandoned by the next header, then a surplus vertex
		send_op(ACT_HEADER, 32'hFFFF_FFFF);
		repeat (3) send_op(ACT_VERTEX, $urandom);
		send_op(ACT_HEADER, 32'd3);
		repeat (3) send_op(ACT_VERTEX, $urandom);
		send_op(ACT_VERTEX, $urandom, 1'b0);
		// begin resets face numbering; face 0 is a hole
		send_op(ACT_BEGIN, '0);
		send_op(ACT_HOLE, 32'd0);
		send_op(ACT_HOLE, 32'hFFFF_FFFF);
		send_op(ACT_HEADER, 32'd3);
		repeat (3) send_op(ACT_VERTEX, $urandom);
		send_op(ACT_HEADER, 32'd3);
		repeat (3) send_op(ACT_VERTEX, $urandom);

		for (int ph = 0; ph < 4; ph++) begin
			write_orientation(ph % 2 == 1);
			src_idle = src_idle_by_phase[ph];
			sink_stall = sink_stall_by_phase[ph];
			if (ph == 0) begin
				// long output hold-off while a big fan fills the block
				hold_req = 1'b1;
				send_op(ACT_BEGIN, '0);
				send_op(ACT_HEADER, 32'd40);
				repeat (40) send_op(ACT_VERTEX, $urandom);
			end
			target = sent_items + PHASE_ITEMS;
			while (sent_items < target) begin
				send_mesh(6);
				if (ph == 1 && sent_items > target - PHASE_ITEMS / 2 && $urandom_range(3) == 0)
					drain(0);
			end
		end

		drain(SETTLE);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
